// ===== hdl/prd_pkg.sv =====
package prd_pkg;

    // Fixed data format of the point and angle fields
    localparam int DATA_W    = 32;
    localparam int ANG_FRAC  = 24;   // CORDIC angle fraction bits (degrees)
    localparam int TRIG_FRAC = 30;   // CORDIC x/y fraction bits
    localparam int TABLE_LEN = 24;
    localparam int CORD_W    = 32;   // CORDIC x/y width
    localparam int ZW        = 32;   // CORDIC residual angle width

    // Trig value fraction bits after the cut ahead of the multipliers
    localparam int TRIG_W = ((62 - DATA_W) < TRIG_FRAC) ? (62 - DATA_W) : TRIG_FRAC;

    // Infinite-step CORDIC gain compensation, Q30
    localparam logic signed [CORD_W-1:0] GAIN_Q30 = CORD_W'(652032874);

    // round(atan(2^-i) * 2^24), in degrees
    localparam logic signed [ZW-1:0] ATAN_DEG_Q24 [TABLE_LEN] = '{
        ZW'(754974720), ZW'(445687602), ZW'(235489088), ZW'(119537938),
        ZW'(60000934),  ZW'(30029717),  ZW'(15018523),  ZW'(7509720),
        ZW'(3754917),   ZW'(1877466),   ZW'(938734),    ZW'(469367),
        ZW'(234684),    ZW'(117342),    ZW'(58671),     ZW'(29335),
        ZW'(14668),     ZW'(7334),      ZW'(3667),      ZW'(1833),
        ZW'(917),       ZW'(458),       ZW'(229),       ZW'(115)
    };

    // 360 deg = 45 * 2^(F+3). Since 2^12 = 1 mod 45, the upper angle bits
    // reduce mod 45 by summing 12-bit chunks.
    localparam int CHUNK_W     = 12;
    localparam int MOD_BASE    = 45;
    localparam int MOD_W       = 6;
    localparam int RECIP_MUL   = 23301;  // floor(2^20 / 45)
    localparam int RECIP_W     = 15;
    localparam int RECIP_SHIFT = 20;

    typedef enum logic [1:0] {
        QUAD_I   = 2'd0,
        QUAD_II  = 2'd1,
        QUAD_III = 2'd2,
        QUAD_IV  = 2'd3
    } quad_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] x_in;
        logic signed [DATA_W-1:0] y_in;
        logic signed [DATA_W-1:0] angle_deg;
    } point_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] x_out;
        logic signed [DATA_W-1:0] y_out;
        logic                     saturated;
    } point_out_t;

endpackage

// ===== hdl/prd_cordic.sv =====
module prd_cordic
    import prd_pkg::*;
#(
    parameter int STEPS  = 16,
    parameter int SIDE_W = 66
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     adv,
    input  logic                     in_valid,
    input  logic signed [ZW-1:0]     in_z,
    input  logic [SIDE_W-1:0]        in_side,
    output logic                     out_valid,
    output logic signed [CORD_W-1:0] out_cos,
    output logic signed [CORD_W-1:0] out_sin,
    output logic [SIDE_W-1:0]        out_side
);

    logic [STEPS-1:0]         valid_reg;
    logic [STEPS-1:0]         valid_next;
    logic signed [CORD_W-1:0] x_reg    [STEPS];
    logic signed [CORD_W-1:0] x_next   [STEPS];
    logic signed [CORD_W-1:0] y_reg    [STEPS];
    logic signed [CORD_W-1:0] y_next   [STEPS];
    logic signed [ZW-1:0]     z_reg    [STEPS];
    logic signed [ZW-1:0]     z_next   [STEPS];
    logic [SIDE_W-1:0]        side_reg [STEPS];
    logic [SIDE_W-1:0]        side_next[STEPS];

    // One micro-rotation per stage; step 0 starts from the gain constant
    always_comb begin
        logic signed [CORD_W-1:0] xs;
        logic signed [CORD_W-1:0] ys;
        logic signed [CORD_W-1:0] dx;
        logic signed [CORD_W-1:0] dy;
        logic signed [ZW-1:0]     zs;
        for (int i = 0; i < STEPS; i++) begin
            if (i == 0) begin
                xs            = GAIN_Q30;
                ys            = '0;
                zs            = in_z;
                valid_next[i] = in_valid;
                side_next[i]  = in_side;
            end else begin
                xs            = x_reg[i-1];
                ys            = y_reg[i-1];
                zs            = z_reg[i-1];
                valid_next[i] = valid_reg[i-1];
                side_next[i]  = side_reg[i-1];
            end
            dx = ys >>> i;
            dy = xs >>> i;
            if (!zs[ZW-1]) begin
                x_next[i] = xs - dx;
                y_next[i] = ys + dy;
                z_next[i] = zs - ATAN_DEG_Q24[i];
            end else begin
                x_next[i] = xs + dx;
                y_next[i] = ys - dy;
                z_next[i] = zs + ATAN_DEG_Q24[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < STEPS; i++) begin
                x_reg[i]    <= x_next[i];
                y_reg[i]    <= y_next[i];
                z_reg[i]    <= z_next[i];
                side_reg[i] <= side_next[i];
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign out_cos   = x_reg[STEPS-1];
    assign out_sin   = y_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule

// ===== hdl/point_rotate_degrees.sv =====
// Channel   Ports                        Direction  Content
// input     s_valid s_ready s_payload    in         point_in_t  (x_in, y_in, angle_deg)
// result    m_valid m_ready m_payload    out        point_out_t (x_out, y_out, saturated)
//
// Fully pipelined: one transaction per clock while m_ready does not stall the output.
// Stages: 3 angle reduction, one per CORDIC step, 3 quadrant map/multiply/round.
// Reset is synchronous on aresetn low and clears only the stage valid bits.
// The whole pipeline advances when the output register is empty or being taken;
// a stall on m_ready freezes every stage, so nothing is dropped or repeated.
module point_rotate_degrees
    import prd_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  point_in_t  s_payload,
    output logic       m_valid,
    input  logic       m_ready,
    output point_out_t m_payload
);

    localparam int STEPS  = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN :
                            ((CORDIC_STEPS < 1) ? 1 : CORDIC_STEPS);
    localparam int LOW_W  = FRAC_BITS + 3;
    localparam int UW_RAW = DATA_W - LOW_W;
    localparam int NCH    = (UW_RAW <= CHUNK_W) ? 1 : (UW_RAW + CHUNK_W - 1) / CHUNK_W;
    localparam int UW     = CHUNK_W * NCH;
    localparam int AW     = UW + LOW_W;
    localparam int SUM_W  = $clog2(NCH * (2 ** CHUNK_W - 1) + MOD_BASE);
    localparam int PROD_W = SUM_W + RECIP_W;
    localparam int QE_W   = PROD_W - RECIP_SHIFT;
    localparam int SIDE_W = 2 + 2 * DATA_W;
    localparam int TW     = TRIG_W + 2;
    localparam int PW     = DATA_W + TW;
    localparam int SW     = PW + 1;
    localparam logic signed [ZW-1:0] Z_LIMIT =
        ZW'(2 * MOD_BASE) << ANG_FRAC;

    logic adv;

    // Whole pipeline moves together unless the output is held
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // ---------------- Stage A: chunk sum of the upper angle bits
    logic                     a_valid_reg;
    logic [SUM_W-1:0]         a_sum_reg;
    logic [SUM_W-1:0]         a_sum_next;
    logic [LOW_W-1:0]         a_low_reg;
    logic signed [DATA_W-1:0] a_x_reg;
    logic signed [DATA_W-1:0] a_y_reg;
    logic signed [AW-1:0]     ang_ext;

    always_comb begin
        ang_ext    = AW'(s_payload.angle_deg);
        a_sum_next = '0;
        for (int k = 0; k < NCH; k++) begin
            a_sum_next = a_sum_next + SUM_W'(ang_ext[LOW_W + k * CHUNK_W +: CHUNK_W]);
        end
        // Sign extension adds 2^UW = 1 (mod 45); undo with +44
        if (ang_ext[AW-1]) begin
            a_sum_next = a_sum_next + SUM_W'(MOD_BASE - 1);
        end
    end

    // ---------------- Stage B: sum mod 45 by reciprocal multiply
    logic                     b_valid_reg;
    logic [MOD_W-1:0]         b_umod_reg;
    logic [MOD_W-1:0]         b_umod_next;
    logic [LOW_W-1:0]         b_low_reg;
    logic signed [DATA_W-1:0] b_x_reg;
    logic signed [DATA_W-1:0] b_y_reg;
    logic [PROD_W-1:0]        recip_prod;
    logic [QE_W-1:0]          q_est;
    logic [SUM_W-1:0]         rem_wide;
    logic [MOD_W:0]           rem_small;

    always_comb begin
        recip_prod = PROD_W'(a_sum_reg) * PROD_W'(RECIP_MUL);
        q_est      = recip_prod[PROD_W-1:RECIP_SHIFT];
        rem_wide   = a_sum_reg - SUM_W'(SUM_W'(q_est) * SUM_W'(MOD_BASE));
        rem_small  = rem_wide[MOD_W:0];
        // Estimate is at most one low
        if (rem_small >= (MOD_W + 1)'(MOD_BASE)) begin
            rem_small = rem_small - (MOD_W + 1)'(MOD_BASE);
        end
        b_umod_next = rem_small[MOD_W-1:0];
    end

    // ---------------- Stage C: quadrant split, angle to Q24 degrees
    logic                     c_valid_reg;
    quad_t                    c_quad_reg;
    quad_t                    c_quad_next;
    logic signed [ZW-1:0]     c_z_reg;
    logic signed [ZW-1:0]     c_z_next;
    logic signed [DATA_W-1:0] c_x_reg;
    logic signed [DATA_W-1:0] c_y_reg;
    logic [MOD_W+1:0]         oct_val;
    logic [MOD_W+1:0]         oct_rem;

    always_comb begin
        // Angle in units of 2 degrees (2^(F+1) LSBs), below 180
        oct_val = {b_umod_reg, b_low_reg[LOW_W-1 -: 2]};
        if (oct_val >= (MOD_W + 2)'(3 * MOD_BASE)) begin
            c_quad_next = QUAD_IV;
            oct_rem     = oct_val - (MOD_W + 2)'(3 * MOD_BASE);
        end else if (oct_val >= (MOD_W + 2)'(2 * MOD_BASE)) begin
            c_quad_next = QUAD_III;
            oct_rem     = oct_val - (MOD_W + 2)'(2 * MOD_BASE);
        end else if (oct_val >= (MOD_W + 2)'(MOD_BASE)) begin
            c_quad_next = QUAD_II;
            oct_rem     = oct_val - (MOD_W + 2)'(MOD_BASE);
        end else begin
            c_quad_next = QUAD_I;
            oct_rem     = oct_val;
        end
        c_z_next = (ZW'(oct_rem) << (ANG_FRAC + 1))
                 | (ZW'(b_low_reg[FRAC_BITS:0]) << (ANG_FRAC - FRAC_BITS));
    end

    // ---------------- CORDIC rotation pipeline
    logic                     k_valid;
    logic signed [CORD_W-1:0] k_cos;
    logic signed [CORD_W-1:0] k_sin;
    logic [SIDE_W-1:0]        k_side;

    prd_cordic #(
        .STEPS  (STEPS),
        .SIDE_W (SIDE_W)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (c_valid_reg),
        .in_z      (c_z_reg),
        .in_side   ({c_quad_reg, c_x_reg, c_y_reg}),
        .out_valid (k_valid),
        .out_cos   (k_cos),
        .out_sin   (k_sin),
        .out_side  (k_side)
    );

    // ---------------- Stage D: quadrant map and trig cut
    logic                     d_valid_reg;
    logic signed [TW-1:0]     d_cos_reg;
    logic signed [TW-1:0]     d_cos_next;
    logic signed [TW-1:0]     d_sin_reg;
    logic signed [TW-1:0]     d_sin_next;
    logic signed [DATA_W-1:0] d_x_reg;
    logic signed [DATA_W-1:0] d_y_reg;
    logic signed [CORD_W-1:0] cos_full;
    logic signed [CORD_W-1:0] sin_full;
    quad_t                    k_quad;

    always_comb begin
        k_quad = quad_t'(k_side[SIDE_W-1 -: 2]);
        case (k_quad)
            QUAD_I: begin
                cos_full = k_cos;
                sin_full = k_sin;
            end
            QUAD_II: begin
                cos_full = -k_sin;
                sin_full = k_cos;
            end
            QUAD_III: begin
                cos_full = -k_cos;
                sin_full = -k_sin;
            end
            default: begin
                cos_full = k_sin;
                sin_full = -k_cos;
            end
        endcase
        d_cos_next = TW'(cos_full >>> (TRIG_FRAC - TRIG_W));
        d_sin_next = TW'(sin_full >>> (TRIG_FRAC - TRIG_W));
    end

    // ---------------- Stage E: four products
    logic                 e_valid_reg;
    logic signed [PW-1:0] e_xc_reg;
    logic signed [PW-1:0] e_ys_reg;
    logic signed [PW-1:0] e_yc_reg;
    logic signed [PW-1:0] e_xs_reg;

    // ---------------- Stage F: sum, round half up, saturate
    logic                 out_valid_reg;
    point_out_t           out_reg;
    point_out_t           out_next;
    logic signed [SW-1:0] sum_x;
    logic signed [SW-1:0] sum_y;
    logic signed [SW-1:0] rnd_x;
    logic signed [SW-1:0] rnd_y;
    logic [SW-DATA_W:0]   hi_x;
    logic [SW-DATA_W:0]   hi_y;
    logic                 ovf_x;
    logic                 ovf_y;

    localparam logic signed [DATA_W-1:0] OUT_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
    localparam logic signed [DATA_W-1:0] OUT_MIN = {1'b1, {(DATA_W - 1){1'b0}}};
    localparam logic signed [SW-1:0]     RND_HALF = SW'(1) << (TRIG_W - 1);

    always_comb begin
        sum_x = SW'(e_xc_reg) + SW'(e_ys_reg) + RND_HALF;
        sum_y = SW'(e_yc_reg) - SW'(e_xs_reg) + RND_HALF;
        rnd_x = sum_x >>> TRIG_W;
        rnd_y = sum_y >>> TRIG_W;
        hi_x  = rnd_x[SW-1:DATA_W-1];
        hi_y  = rnd_y[SW-1:DATA_W-1];
        ovf_x = !((&hi_x) || !(|hi_x));
        ovf_y = !((&hi_y) || !(|hi_y));
        if (ovf_x) begin
            out_next.x_out = rnd_x[SW-1] ? OUT_MIN : OUT_MAX;
        end else begin
            out_next.x_out = rnd_x[DATA_W-1:0];
        end
        if (ovf_y) begin
            out_next.y_out = rnd_y[SW-1] ? OUT_MIN : OUT_MAX;
        end else begin
            out_next.y_out = rnd_y[DATA_W-1:0];
        end
        out_next.saturated = ovf_x || ovf_y;
    end

    // Stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg   <= s_valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= k_valid;
            e_valid_reg   <= d_valid_reg;
            out_valid_reg <= e_valid_reg;
        end
    end

    // Stage data
    always_ff @(posedge aclk) begin
        if (adv) begin
            a_sum_reg  <= a_sum_next;
            a_low_reg  <= ang_ext[LOW_W-1:0];
            a_x_reg    <= s_payload.x_in;
            a_y_reg    <= s_payload.y_in;
            b_umod_reg <= b_umod_next;
            b_low_reg  <= a_low_reg;
            b_x_reg    <= a_x_reg;
            b_y_reg    <= a_y_reg;
            c_quad_reg <= c_quad_next;
            c_z_reg    <= c_z_next;
            c_x_reg    <= b_x_reg;
            c_y_reg    <= b_y_reg;
            d_cos_reg  <= d_cos_next;
            d_sin_reg  <= d_sin_next;
            d_x_reg    <= k_side[2*DATA_W-1:DATA_W];
            d_y_reg    <= k_side[DATA_W-1:0];
            e_xc_reg   <= PW'(d_x_reg) * PW'(d_cos_reg);
            e_ys_reg   <= PW'(d_y_reg) * PW'(d_sin_reg);
            e_yc_reg   <= PW'(d_y_reg) * PW'(d_cos_reg);
            e_xs_reg   <= PW'(d_x_reg) * PW'(d_sin_reg);
            out_reg    <= out_next;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

    // Nothing leaves the block in the cycle after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Reduced upper angle is a residue mod 45
    assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg |-> (b_umod_reg < MOD_W'(MOD_BASE)))
        else $error("angle residue out of range");

    // CORDIC start angle lies in [0, 90) degrees
    assert property (@(posedge aclk) disable iff (!aresetn)
        c_valid_reg |-> (!c_z_reg[ZW-1] && (c_z_reg < Z_LIMIT)))
        else $error("reduced angle outside first quadrant");

    // A clip flag means at least one coordinate sits on a bound
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.saturated) |->
            (m_payload.x_out == OUT_MAX || m_payload.x_out == OUT_MIN ||
             m_payload.y_out == OUT_MAX || m_payload.y_out == OUT_MIN))
        else $error("saturation flag without clipped result");

endmodule

// ===== bench/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import prd_pkg::*;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int PIPE_LATENCY = CORDIC_STEPS + 6;
    localparam int RANDOM_ITEMS = 1700;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int MAX_REPORTS  = 10;

    // Angle format inside the rotator: degrees with 24 fraction bits
    localparam int DEG_FRAC   = 24;
    localparam int SINCOS_FRAC = 30;
    localparam int STEP_COUNT  = 24;
    localparam longint UNIT_GAIN = 652032874;   // 1/K in Q30
    localparam longint ATAN_STEP_DEG [STEP_COUNT] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    localparam logic signed [DATA_W-1:0] MAXV = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] MINV = {1'b1, {(DATA_W-1){1'b0}}};
    localparam int DEG1    = 1 << FRAC_BITS;
    localparam int QUARTER = 90 * DEG1;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] a;
        logic                     typed;
        point_out_t               want;
    } rotation_case_t;

    // Directed cases; typed rows carry a result that needs no arithmetic
    localparam int NUM_CASES = 24;
    localparam rotation_case_t ROTATION_CASES [NUM_CASES] = '{
        '{0, 0, 0, 1'b1, '0},
        '{0, 0, MAXV, 1'b1, '0},
        '{0, 0, MINV, 1'b1, '0},
        '{DEG1, 0, 0, 1'b0, '0},
        '{DEG1, 0, QUARTER, 1'b0, '0},
        '{DEG1, 0, 2 * QUARTER, 1'b0, '0},
        '{DEG1, 0, 3 * QUARTER, 1'b0, '0},
        '{DEG1, 0, 4 * QUARTER, 1'b0, '0},
        '{DEG1, 0, -QUARTER, 1'b0, '0},          // negative angle wraps to 270
        '{0, DEG1, 45 * DEG1, 1'b0, '0},
        '{DEG1, DEG1, QUARTER - 1, 1'b0, '0},     // just under a quadrant edge
        '{MAXV, MAXV, 45 * DEG1, 1'b0, '0},       // clips high
        '{MINV, MINV, 45 * DEG1, 1'b0, '0},       // clips low
        '{MAXV, MINV, 135 * DEG1, 1'b0, '0},
        '{MINV, MAXV, 315 * DEG1, 1'b0, '0},
        '{MAXV, 0, 0, 1'b0, '0},
        '{MINV, 0, 2 * QUARTER, 1'b0, '0},        // negating the minimum overflows
        '{0, MINV, 0, 1'b0, '0},
        '{-1, -1, 1, 1'b0, '0},
        '{100 * DEG1, -50 * DEG1, MAXV, 1'b0, '0},
        '{-3 * DEG1, 7 * DEG1, MINV, 1'b0, '0},
        '{12345, -54321, -8 * QUARTER - 1, 1'b0, '0},
        '{DEG1, 0, 30 * DEG1, 1'b0, '0},
        '{DEG1, DEG1, -1000 * DEG1 + 1, 1'b0, '0}
    };

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    point_in_t  s_payload = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    point_out_t m_payload;

    // Side data traveling with the current input transaction
    logic       row_typed = 1'b0;
    point_out_t row_want  = '0;

    point_out_t pending_rotations [$];
    point_out_t oldest_rotation;
    int         rotation_failures = 0;
    int         cycle_count       = 0;

    point_rotate_degrees #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Clockwise rotation with CORDIC sine/cosine, rounded and clipped
    function automatic point_out_t rotate_point(point_in_t p);
        longint     px, py, ang, span, full, m, r, z, cx, cy, dx, dy;
        longint     c, s, sx, sy, hi, lo;
        int         q, steps, tf;
        logic       clip;
        point_out_t res;
        px   = longint'(p.x_in);
        py   = longint'(p.y_in);
        ang  = longint'(p.angle_deg);
        span = longint'(90) <<< FRAC_BITS;
        full = 4 * span;

        // true modulo, then quadrant and remainder
        m = ang % full;
        if (m < 0) m += full;
        q = int'(m / span);
        r = m - q * span;
        if (DEG_FRAC >= FRAC_BITS) z = r <<< (DEG_FRAC - FRAC_BITS);
        else z = r >>> (FRAC_BITS - DEG_FRAC);

        steps = (CORDIC_STEPS > STEP_COUNT) ? STEP_COUNT : CORDIC_STEPS;
        if (steps < 0) steps = 0;
        cx = UNIT_GAIN;
        cy = 0;
        for (int i = 0; i < steps; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (z >= 0) begin
                cx -= dx;
                cy += dy;
                z  -= ATAN_STEP_DEG[i];
            end else begin
                cx += dx;
                cy -= dy;
                z  += ATAN_STEP_DEG[i];
            end
        end

        case (quad_t'(q[1:0]))
            QUAD_I: begin
                c = cx;  s = cy;
            end
            QUAD_II: begin
                c = -cy; s = cx;
            end
            QUAD_III: begin
                c = -cx; s = -cy;
            end
            default: begin
                c = cy;  s = -cx;
            end
        endcase

        tf = ((62 - DATA_W) < SINCOS_FRAC) ? (62 - DATA_W) : SINCOS_FRAC;
        c  = c >>> (SINCOS_FRAC - tf);
        s  = s >>> (SINCOS_FRAC - tf);
        sx = px * c + py * s;
        sy = py * c - px * s;
        sx = (sx + (longint'(1) <<< (tf - 1))) >>> tf;
        sy = (sy + (longint'(1) <<< (tf - 1))) >>> tf;

        hi   = (longint'(1) <<< (DATA_W - 1)) - 1;
        lo   = -hi - 1;
        clip = 1'b0;
        if (sx > hi) begin
            sx = hi; clip = 1'b1;
        end else if (sx < lo) begin
            sx = lo; clip = 1'b1;
        end
        if (sy > hi) begin
            sy = hi; clip = 1'b1;
        end else if (sy < lo) begin
            sy = lo; clip = 1'b1;
        end
        res.x_out     = sx[DATA_W-1:0];
        res.y_out     = sy[DATA_W-1:0];
        res.saturated = clip;
        return res;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_coord();
        logic signed [DATA_W-1:0] v;
        v = $urandom();
        case ($urandom_range(0, 7))
            0, 1, 2: return v;
            3, 4:    return int'($urandom_range(0, 2 << 20)) - (1 << 20);
            5:       return int'($urandom_range(0, 512 * DEG1)) - 256 * DEG1;
            6: begin
                case ($urandom_range(0, 3))
                    0:       return MAXV;
                    1:       return MINV;
                    2:       return 0;
                    default: return -1;
                endcase
            end
            default: return v >>> $urandom_range(0, 30);
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_angle();
        int k;
        k = int'($urandom_range(0, 24)) - 12;
        case ($urandom_range(0, 9))
            0, 1:    return $urandom();
            2, 3:    return k * QUARTER;
            4:       return k * QUARTER + int'($urandom_range(0, 16)) - 8;
            5:       return ($urandom_range(0, 1) == 0) ? MAXV : MINV;
            default: return int'($urandom_range(0, 1440 * DEG1)) - 720 * DEG1;
        endcase
    endfunction

    // Idle cycles between input transactions for a given gap style
    function automatic int pick_gap(int style);
        int roll;
        roll = $urandom_range(0, 99);
        if (style == 0) return 0;
        if (style == 1) begin
            if (roll < 70) return 0;
            if (roll < 95) return $urandom_range(1, 3);
            return $urandom_range(10, 40);
        end
        if (roll < 30) return 0;
        if (roll < 85) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_point(input point_in_t p, input logic typed, input point_out_t want);
        s_valid   <= 1'b1;
        s_payload <= p;
        row_typed <= typed;
        row_want  <= want;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    task automatic note_failure(input string msg);
        rotation_failures++;
        if (rotation_failures <= MAX_REPORTS) $display("%s", msg);
    endtask

    // Result side: random stalls, occasional long free-running stretches
    int ready_stall = 0;
    int ready_free  = 0;
    int ready_roll;
    always @(posedge aclk) begin
        if (ready_free > 0) begin
            ready_free--;
            m_ready <= 1'b1;
        end else if (ready_stall > 0) begin
            ready_stall--;
            m_ready <= 1'b0;
        end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 3) begin
                ready_free = $urandom_range(100, 300);
                m_ready <= 1'b1;
            end else if (ready_roll < 20) begin
                ready_stall = $urandom_range(0, 2);
                m_ready <= 1'b0;
            end else if (ready_roll < 23) begin
                ready_stall = $urandom_range(10, 40);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Predict on each input transaction, check each result transaction
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                pending_rotations.push_back(row_typed ? row_want : rotate_point(s_payload));
            if (m_valid && m_ready) begin
                if (pending_rotations.size() == 0) begin
                    note_failure($sformatf("unexpected result at cycle %0d: x %0d y %0d sat %0b",
                        cycle_count, m_payload.x_out, m_payload.y_out, m_payload.saturated));
                end else begin
                    oldest_rotation = pending_rotations.pop_front();
                    if (m_payload.x_out !== oldest_rotation.x_out ||
                        m_payload.y_out !== oldest_rotation.y_out ||
                        m_payload.saturated !== oldest_rotation.saturated)
                        note_failure($sformatf(
                            "rotation mismatch at cycle %0d: want x %0d y %0d sat %0b, got x %0d y %0d sat %0b",
                            cycle_count, oldest_rotation.x_out, oldest_rotation.y_out,
                            oldest_rotation.saturated, m_payload.x_out, m_payload.y_out,
                            m_payload.saturated));
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL point_rotate_degrees");
            $finish;
        end
    end

    initial begin
        point_in_t pt;
        int        gap_style;
        gap_style = 1;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed cases
        foreach (ROTATION_CASES[i]) begin
            pt.x_in      = ROTATION_CASES[i].x;
            pt.y_in      = ROTATION_CASES[i].y;
            pt.angle_deg = ROTATION_CASES[i].a;
            send_point(pt, ROTATION_CASES[i].typed, ROTATION_CASES[i].want);
            hold_off(pick_gap(1));
        end

        // Random points, gap style changes every hundred transactions
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) gap_style = $urandom_range(0, 2);
            if (n == 600 || n == 1300) begin
                // let the pipeline run dry before going on
                s_valid <= 1'b0;
                do @(posedge aclk); while (pending_rotations.size() != 0);
                @(posedge aclk);
            end
            pt.x_in      = pick_coord();
            pt.y_in      = pick_coord();
            pt.angle_deg = pick_angle();
            send_point(pt, 1'b0, '0);
            hold_off(pick_gap(gap_style));
        end
        s_valid <= 1'b0;

        // Drain, then watch for stray results
        do @(posedge aclk); while (pending_rotations.size() != 0);
        repeat (PIPE_LATENCY + 8) @(posedge aclk);

        if (rotation_failures == 0 && pending_rotations.size() == 0)
            $display("PASS point_rotate_degrees");
        else
            $display("FAIL point_rotate_degrees");
        $finish;
    end

endmodule
